// ===== design/flash_tally_session_counter_core_assert.svh =====
// assertion macros for the session counter core
// depends on a clock named clock and a synchronous active-high reset named reset
`ifndef FLASH_TALLY_SESSION_COUNTER_CORE_ASSERT_SVH
`define FLASH_TALLY_SESSION_COUNTER_CORE_ASSERT_SVH

// same-cycle implication
`define FTSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ftsc check failed");

// next-cycle implication
`define FTSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ftsc check failed");

`endif

// ===== design/ftsc_pkg.sv =====
// shared types and constants for the flash tally session counter
// no dependencies
package ftsc_pkg;

   localparam int TALLY_BYTES = 506;
   localparam int IDX_W = (TALLY_BYTES > 1) ? $clog2(TALLY_BYTES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TALLY_BYTES - 1);

   localparam logic [7:0] TALLY_ZERO = 8'hFF;
   localparam logic [7:0] TALLY_ONE  = 8'hFE;
   localparam logic [7:0] TALLY_TWO  = 8'hFC;

   // weight of a corrupt tally byte, wrapped to 16 bits
   localparam logic [15:0] CORRUPT_ADD = 16'((2 * TALLY_BYTES + 1) % 65536);
   localparam logic [15:0] ERASED_BASE = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_INCR  = 2'd1,
      CMD_PROG  = 2'd2,
      CMD_ERASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PAGE_KEEP,
      PAGE_NEW_ZERO,
      PAGE_NEW_NEXT,
      PAGE_ERASE
   } page_op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_PROG_RD,
      ST_PROG_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        scan_init;
      logic        scan_run;
      logic        scan_incr;
      logic        clr_run;
      logic        prog_rd;
      logic        prog_wr;
      page_op_type page_op;
      logic        mark_first;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic page_valid;
      logic index_ok;
      logic scan_stop;
      logic scan_hit;
      logic clr_last;
   } dp_stat_type;

endpackage

// ===== design/ftsc_ram.sv =====
// generic single-port-write, one-read-port ram with registered read data
// no dependencies
module ftsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ftsc_ctrl.sv =====
// controller state machine for the session counter
// depends on ftsc_pkg
module ftsc_ctrl import ftsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_cmd,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   cmd_type   op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   cmd_type   req_op;

   assign req_op    = cmd_type'(req_cmd);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         op_ff        <= CMD_READ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               unique case (req_op)
                  CMD_READ, CMD_INCR: state_in = stat.page_valid ? ST_SCAN : ST_CLEAR;
                  CMD_PROG:           state_in = stat.index_ok ? ST_PROG_RD : ST_DONE;
                  CMD_ERASE:          state_in = ST_CLEAR;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.scan_stop) begin
               state_in = (op_ff == CMD_INCR && !stat.scan_hit) ? ST_CLEAR : ST_DONE;
            end
         end
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_DONE;
         end
         ST_PROG_RD: state_in = ST_PROG_WR;
         ST_PROG_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      cmd.page_op = PAGE_KEEP;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: cmd.clr_run = 1'b1;
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_op)
                  CMD_READ, CMD_INCR: begin
                     if (stat.page_valid) begin
                        cmd.scan_init = 1'b1;
                     end else begin
                        cmd.page_op    = PAGE_NEW_ZERO;
                        cmd.mark_first = (req_op == CMD_INCR);
                     end
                  end
                  CMD_PROG:  cmd.page_op = PAGE_KEEP;
                  CMD_ERASE: cmd.page_op = PAGE_ERASE;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_incr = (op_ff == CMD_INCR);
            if (stat.scan_stop && op_ff == CMD_INCR && !stat.scan_hit) begin
               cmd.page_op = PAGE_NEW_NEXT;
            end
         end
         ST_PROG_RD: cmd.prog_rd = 1'b1;
         ST_PROG_WR: cmd.prog_wr = 1'b1;
         ST_DONE:    cmd.load_rsp = slot_free;
         default:    cmd.page_op = PAGE_KEEP;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/ftsc_dpath.sv =====
// datapath: page header, tally ram, scan accumulator and result registers
// depends on ftsc_pkg and ftsc_ram
module ftsc_dpath import ftsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [8:0]  req_tally_index,
   input  logic [7:0]  req_program_byte,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output logic [15:0] rsp_session_value,
   output logic        rsp_page_rewritten,
   output logic        rsp_corrupt_seen
);

   logic [15:0]      base_ff;
   logic             page_valid_ff;
   logic             first_one_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [IDX_W-1:0] scan_idx_ff;
   logic [IDX_W-1:0] scan_pos_ff;
   logic             scan_pend_ff;
   logic [15:0]      sum_ff;
   logic             bad_ff;
   logic [IDX_W-1:0] index_ff;
   logic [7:0]       pbyte_ff;
   logic [15:0]      res_value_ff;
   logic             res_rew_ff;
   logic             res_bad_ff;
   logic [15:0]      rsp_value_ff;
   logic             rsp_rew_ff;
   logic             rsp_bad_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   logic             is_zero, is_one, is_two;
   logic             scan_hit, scan_stop;
   logic [15:0]      step;
   logic [15:0]      sum_step;
   logic [15:0]      scan_value;
   logic             scan_bad;

   ftsc_ram #(
      .WIDTH (8),
      .DEPTH (TALLY_BYTES)
   ) u_tally_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // scan evaluation of the byte that came back from the ram
   assign is_zero   = (rd_data == TALLY_ZERO);
   assign is_one    = (rd_data == TALLY_ONE);
   assign is_two    = (rd_data == TALLY_TWO);
   assign scan_hit  = scan_pend_ff && (is_zero || is_one);
   assign scan_stop = scan_pend_ff && (scan_hit || scan_pos_ff == LAST_IDX);
   assign scan_bad  = bad_ff || (scan_pend_ff && !is_zero && !is_one && !is_two);

   always_comb begin
      priority if (!scan_pend_ff) step = 16'd0;
      else if (is_zero)           step = 16'd0;
      else if (is_one)            step = 16'd1;
      else if (is_two)            step = 16'd2;
      else                        step = CORRUPT_ADD;
   end

   assign sum_step   = sum_ff + step;
   assign scan_value = sum_step + {15'd0, cmd.scan_incr};

   // ram port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_idx_ff;
      wr_data = TALLY_ZERO;
      priority if (cmd.clr_run) begin
         wr_en   = 1'b1;
         wr_data = (clr_idx_ff == '0 && first_one_ff) ? TALLY_ONE : TALLY_ZERO;
      end else if (cmd.prog_wr) begin
         wr_en   = 1'b1;
         wr_addr = index_ff;
         wr_data = rd_data & pbyte_ff;
      end else if (cmd.scan_run && cmd.scan_incr && scan_hit) begin
         wr_en   = 1'b1;
         wr_addr = scan_pos_ff;
         wr_data = is_zero ? TALLY_ONE : TALLY_TWO;
      end else begin
         wr_en   = 1'b0;
      end
   end

   assign rd_addr = cmd.prog_rd ? index_ff : scan_idx_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= 16'd0;
         page_valid_ff <= 1'b0;
         first_one_ff  <= 1'b0;
         clr_idx_ff    <= '0;
         scan_pend_ff  <= 1'b0;
      end else begin
         unique case (cmd.page_op)
            PAGE_KEEP: begin
            end
            PAGE_NEW_ZERO: begin
               base_ff       <= 16'd0;
               page_valid_ff <= 1'b1;
               first_one_ff  <= cmd.mark_first;
            end
            PAGE_NEW_NEXT: begin
               base_ff       <= scan_value;
               page_valid_ff <= 1'b1;
               first_one_ff  <= 1'b0;
            end
            PAGE_ERASE: begin
               base_ff       <= ERASED_BASE;
               page_valid_ff <= 1'b0;
               first_one_ff  <= 1'b0;
            end
            default: begin
            end
         endcase
         if (cmd.clr_run) begin
            clr_idx_ff <= (clr_idx_ff == LAST_IDX) ? '0 : clr_idx_ff + 1'b1;
         end
         if (cmd.scan_init) begin
            scan_pend_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            scan_pend_ff <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         index_ff     <= IDX_W'(req_tally_index);
         pbyte_ff     <= req_program_byte;
         // a fresh page answers 0 for a read and 1 for an increment
         res_value_ff <= (cmd.page_op == PAGE_NEW_ZERO) ? {15'd0, cmd.mark_first} : 16'd0;
         res_rew_ff   <= (cmd.page_op == PAGE_NEW_ZERO);
         res_bad_ff   <= 1'b0;
      end
      if (cmd.scan_init) begin
         scan_idx_ff <= '0;
         sum_ff      <= base_ff;
         bad_ff      <= 1'b0;
      end else if (cmd.scan_run) begin
         sum_ff      <= sum_step;
         bad_ff      <= scan_bad;
         scan_pos_ff <= scan_idx_ff;
         if (scan_idx_ff != LAST_IDX) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (scan_stop) begin
            res_value_ff <= scan_value;
            res_bad_ff   <= scan_bad;
         end
      end
      if (cmd.page_op == PAGE_NEW_NEXT) begin
         res_rew_ff <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_value_ff <= res_value_ff;
         rsp_rew_ff   <= res_rew_ff;
         rsp_bad_ff   <= res_bad_ff;
      end
   end

   assign stat.page_valid = page_valid_ff;
   assign stat.index_ok   = ({23'd0, req_tally_index} < 32'(TALLY_BYTES));
   assign stat.scan_stop  = scan_stop;
   assign stat.scan_hit   = scan_hit;
   assign stat.clr_last   = (clr_idx_ff == LAST_IDX);

   assign rsp_session_value  = rsp_value_ff;
   assign rsp_page_rewritten = rsp_rew_ff;
   assign rsp_corrupt_seen   = rsp_bad_ff;

endmodule

// ===== design/flash_tally_session_counter_core.sv =====
// top level of the flash tally session counter
// depends on ftsc_pkg, ftsc_ctrl, ftsc_dpath and the assertion macro header

// Monotonic 16-bit session counter held as a page base value, a page-valid
// mark and TALLY_BYTES (506) unary tally bytes in a single tally ram. One
// command is in flight at a time; the result sits in an output register so a
// new command can be taken while the previous result still waits for its
// transfer. The tally ram has one read and one write port and moves one byte
// per cycle. A read scans the tally bytes up to and including the first one
// that is not full (1 to 506 bytes), an increment does the same and adds a
// page rewrite when no byte can be advanced, a read or increment on an
// invalid page and an erase clear the whole page, a tally program reads and
// then writes one byte, and one with an index past the page does neither.
// The result shows on rsp_valid the cycle after it is loaded, and loading
// waits while an earlier result is still stalled in the output register.
// After reset a clearing pass erases the tally ram and req_stall stays high
// until it finishes.
module flash_tally_session_counter_core import ftsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [8:0]  req_tally_index,
   input  logic [7:0]  req_program_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_session_value,
   output logic        rsp_page_rewritten,
   output logic        rsp_corrupt_seen
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: decodes commands, walks scan, clear and program steps
   ftsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // page header, tally ram, scan adder and result registers
   ftsc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_tally_index    (req_tally_index),
      .req_program_byte   (req_program_byte),
      .cmd                (dp_cmd),
      .stat               (dp_stat),
      .rsp_session_value  (rsp_session_value),
      .rsp_page_rewritten (rsp_page_rewritten),
      .rsp_corrupt_seen   (rsp_corrupt_seen)
   );

`include "flash_tally_session_counter_core_assert.svh"

   // one command at a time: after a transfer in, the input side is busy
   `FTSC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // a result is only loaded when the output register is free or draining
   `FTSC_ASSERT_NOW(a_load_into_free_slot, dp_cmd.load_rsp, !rsp_valid || !rsp_stall)
   // only one user of the tally ram port at a time
   `FTSC_ASSERT_NOW(a_ram_port_exclusive, 1'b1,
      $onehot0({dp_cmd.clr_run, dp_cmd.scan_run, dp_cmd.prog_rd, dp_cmd.prog_wr}))

endmodule

// ===== bench/flash_tally_session_counter_core_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for flash_tally_session_counter_core: random command traffic,
// a cycle-free model of the tally page and a scoreboard for the result channel
// depends on ftsc_pkg and the design files of the counter core
module flash_tally_session_counter_core_test import ftsc_pkg::*; ();

   localparam int HOLD_CYCLES    = 4000;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 20000;  // cycles without any transfer
   localparam int DRAIN_CYCLES   = 1100;   // worst increment: scan plus page rewrite
   localparam int MAX_INDEX      = 511;    // all ones on the 9-bit index field

   typedef struct packed {
      logic [15:0] value;
      logic        rewritten;
      logic        corrupt;
   } session_rsp_type;

   // model of the tally page plus the queue of results still owed by the core
   class tally_ledger;
      logic [15:0]     base;
      logic            marked;
      logic [7:0]      tallies [TALLY_BYTES];
      session_rsp_type expected_results [$];
      int              errors;
      int              checked;
      int              rewrites;
      int              corrupt_scans;
      int              cmd_count [4];

      function new();
         erase_tallies();
         base = 16'h0000;
         marked = 1'b0;
         errors = 0;
         checked = 0;
         rewrites = 0;
         corrupt_scans = 0;
         foreach (cmd_count[k]) cmd_count[k] = 0;
      endfunction

      function void erase_tallies();
         foreach (tallies[k]) tallies[k] = TALLY_ZERO;
      endfunction

      // sum of base and tallies up to the first byte that is not full
      function logic [15:0] scan_sum(output logic bad);
         logic [15:0] sum;
         logic        stop;
         int          k;
         sum = base;
         stop = 1'b0;
         bad = 1'b0;
         for (k = 0; k < TALLY_BYTES && !stop; k++) begin
            if (tallies[k] == TALLY_ZERO) begin
               stop = 1'b1;
            end else if (tallies[k] == TALLY_ONE) begin
               sum = sum + 16'd1;
               stop = 1'b1;
            end else if (tallies[k] == TALLY_TWO) begin
               sum = sum + 16'd2;
            end else begin
               bad = 1'b1;
               sum = sum + CORRUPT_ADD;
            end
         end
         return sum;
      endfunction

      function session_rsp_type predict_session(cmd_type c, logic [8:0] idx, logic [7:0] pb);
         session_rsp_type r;
         logic            advanced;
         int              k;
         r = '0;
         if (c == CMD_READ || c == CMD_INCR) begin
            if (!marked) begin
               // invalid page: fresh page with base zero
               erase_tallies();
               base = 16'h0000;
               marked = 1'b1;
               r.rewritten = 1'b1;
            end else begin
               r.value = scan_sum(r.corrupt);
            end
            if (c == CMD_INCR) begin
               r.value = r.value + 16'd1;
               advanced = 1'b0;
               for (k = 0; k < TALLY_BYTES && !advanced; k++) begin
                  if (tallies[k] == TALLY_ZERO) begin
                     tallies[k] = TALLY_ONE;
                     advanced = 1'b1;
                  end else if (tallies[k] == TALLY_ONE) begin
                     tallies[k] = TALLY_TWO;
                     advanced = 1'b1;
                  end else if (tallies[k] != TALLY_TWO) begin
                     r.corrupt = 1'b1;   // corrupt bytes are skipped, never written
                  end
               end
               if (!advanced) begin
                  // full page: rewrite with the new value as base
                  erase_tallies();
                  base = r.value;
                  marked = 1'b1;
                  r.rewritten = 1'b1;
               end
            end
         end else if (c == CMD_PROG) begin
            if (idx < TALLY_BYTES) tallies[idx] = tallies[idx] & pb;
         end else begin
            erase_tallies();
            base = ERASED_BASE;
            marked = 1'b0;
         end
         return r;
      endfunction

      function void log_command(cmd_type c, logic [8:0] idx, logic [7:0] pb);
         cmd_count[c]++;
         expected_results.push_back(predict_session(c, idx, pb));
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task match_response(logic [15:0] value, logic rewritten, logic corrupt);
         session_rsp_type e;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, value %h", value));
         end else begin
            e = expected_results.pop_front();
            checked++;
            if (e.rewritten) rewrites++;
            if (e.corrupt) corrupt_scans++;
            if (value !== e.value)
               report_mismatch($sformatf("session_value %h, want %h", value, e.value));
            if (rewritten !== e.rewritten)
               report_mismatch($sformatf("page_rewritten %b, want %b", rewritten, e.rewritten));
            if (corrupt !== e.corrupt)
               report_mismatch($sformatf("corrupt_seen %b, want %b", corrupt, e.corrupt));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [8:0]  req_tally_index;
   logic [7:0]  req_program_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_session_value;
   logic        rsp_page_rewritten;
   logic        rsp_corrupt_seen;

   tally_ledger board;
   int          idle_cycles;
   int          send_left;
   bit          send_quiet;

   flash_tally_session_counter_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_tally_index    (req_tally_index),
      .req_program_byte   (req_program_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_session_value  (rsp_session_value),
      .rsp_page_rewritten (rsp_page_rewritten),
      .rsp_corrupt_seen   (rsp_corrupt_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 48);
   endfunction

   // transfer monitor: results are checked before the new command is logged
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            board.match_response(rsp_session_value, rsp_page_rewritten, rsp_corrupt_seen);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            board.log_command(cmd_type'(req_cmd), req_tally_index, req_program_byte);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_valid === 1'b1 && req_stall === 1'b0)
            || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("flash_tally_session_counter_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stalls in stretches, with one long hold-off to back up the core
   initial begin : receiver
      int  n;
      int  left;
      bit  quiet;
      bit  held_off;
      rsp_stall = 1'b0;
      left = 0;
      quiet = 1'b0;
      held_off = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!held_off && board.checked >= 100) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (left == 0) begin
               quiet = ($urandom_range(0, 3) == 0);
               left = $urandom_range(20, 120);
            end
            left--;
            n = quiet ? 0 : idle_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // one command transfer; valid stays high straight into the next one when there is no gap
   task automatic send_cmd(input cmd_type c, input logic [8:0] idx, input logic [7:0] pb);
      int gap;
      if (send_left == 0) begin
         send_quiet = ($urandom_range(0, 3) == 0);
         send_left = $urandom_range(20, 80);
      end
      send_left--;
      gap = send_quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_tally_index <= idx;
      req_program_byte <= pb;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // mostly increments and programs near the front of the page, some noise
   task automatic random_burst(input int count);
      int          k;
      int          r;
      cmd_type     c;
      logic [8:0]  idx;
      logic [7:0]  pb;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 25) c = CMD_READ;
         else if (r < 62) c = CMD_INCR;
         else if (r < 96) c = CMD_PROG;
         else c = CMD_ERASE;
         r = $urandom_range(0, 99);
         if (r < 70) idx = 9'($urandom_range(0, 23));
         else if (r < 90) idx = 9'($urandom_range(0, TALLY_BYTES - 1));
         else idx = 9'($urandom_range(TALLY_BYTES, MAX_INDEX));
         r = $urandom_range(0, 99);
         if (r < 35) pb = TALLY_TWO;
         else if (r < 55) pb = TALLY_ONE;
         else if (r < 65) pb = TALLY_ZERO;
         else pb = 8'($urandom);
         send_cmd(c, idx, pb);
      end
   endtask

   initial begin : stimulus
      int k;
      board = new();
      idle_cycles = 0;
      send_left = 0;
      send_quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_READ;
      req_tally_index = '0;
      req_program_byte = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: invalid page, tally steps, corrupt bytes, index edges, erase
      send_cmd(CMD_READ, 9'd0, 8'h00);          // unmarked page after reset
      send_cmd(CMD_INCR, 9'd511, 8'hFF);
      send_cmd(CMD_INCR, 9'd0, 8'h00);
      send_cmd(CMD_READ, 9'd0, 8'h00);
      send_cmd(CMD_PROG, 9'd1, 8'h00);          // corrupt second byte
      send_cmd(CMD_READ, 9'd0, 8'h00);
      send_cmd(CMD_INCR, 9'd0, 8'h00);          // skips the corrupt byte
      send_cmd(CMD_PROG, 9'd505, TALLY_TWO);    // last tally byte
      send_cmd(CMD_PROG, 9'd506, 8'h00);        // first index past the page
      send_cmd(CMD_PROG, 9'd511, 8'h00);
      send_cmd(CMD_PROG, 9'd0, 8'hFF);
      send_cmd(CMD_READ, 9'd0, 8'h00);
      send_cmd(CMD_ERASE, 9'd0, 8'h00);
      send_cmd(CMD_PROG, 9'd3, TALLY_ONE);      // program while unmarked
      send_cmd(CMD_INCR, 9'd0, 8'h00);          // unmarked page on increment
      send_cmd(CMD_PROG, 9'd0, 8'h7F);
      send_cmd(CMD_READ, 9'd0, 8'h00);
      send_cmd(CMD_ERASE, 9'd0, 8'h00);
      send_cmd(CMD_READ, 9'd0, 8'h00);

      random_burst(320);

      // fill every tally byte so the next increment finds a full page;
      // scattered corrupt bytes push the sum past the 16-bit wrap
      send_cmd(CMD_READ, 9'($urandom), 8'($urandom));
      for (k = 0; k < TALLY_BYTES; k++)
         send_cmd(CMD_PROG, 9'(k),
                  ($urandom_range(0, 5) == 0) ? (8'($urandom) & TALLY_TWO) : TALLY_TWO);
      send_cmd(CMD_READ, 9'($urandom), 8'($urandom));
      send_cmd(CMD_INCR, 9'($urandom), 8'($urandom));
      send_cmd(CMD_READ, 9'($urandom), 8'($urandom));

      random_burst(330);
      req_valid <= 1'b0;

      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.expected_results.size() != 0)
         board.report_mismatch($sformatf("%0d results never arrived",
                                         board.expected_results.size()));

      $display("ran %0d reads, %0d increments, %0d tally programs, %0d erases",
               board.cmd_count[CMD_READ], board.cmd_count[CMD_INCR],
               board.cmd_count[CMD_PROG], board.cmd_count[CMD_ERASE]);
      $display("%0d results checked, %0d page rewrites, %0d scans over corrupt bytes",
               board.checked, board.rewrites, board.corrupt_scans);
      if (board.errors == 0) begin
         $display("flash_tally_session_counter_core test passed");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("flash_tally_session_counter_core test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/ftsc_pkg.sv
design/ftsc_ram.sv
design/ftsc_ctrl.sv
design/ftsc_dpath.sv
design/flash_tally_session_counter_core.sv
bench/flash_tally_session_counter_core_test.sv
